FILE: sv/rpl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the random pair link placer.
// No dependencies; imported by rpl_pick, random_pair_link_placer_top and the testbench.

package rpl_pkg;

  localparam int NODE_W  = 8;
  localparam int DEG_W   = 8;
  localparam int DRAW_W  = 16;
  localparam int LINK_W  = 15;
  localparam int RETRY_W = 16;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [RETRY_W-1:0] RETRY_RESET = 16'd64;

  typedef enum logic {
    ACT_LOAD    = 1'b0,
    ACT_ATTEMPT = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    STAT_ADDED       = 3'd0,
    STAT_FIRST_FULL  = 3'd1,
    STAT_SECOND_FULL = 3'd2,
    STAT_DUPLICATE   = 3'd3,
    STAT_GAVE_UP     = 3'd4,
    STAT_DONE_OK     = 3'd5,
    STAT_DONE_SHORT  = 3'd6,
    STAT_LOADED      = 3'd7
  } status_e;

  typedef enum logic {
    REG_LINK_TARGET = 1'b0,
    REG_RETRY_LIMIT = 1'b1
  } reg_idx_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD,
    S_DECIDE,
    S_RD_I,
    S_RD_J,
    S_CHK_J,
    S_CHK_A,
    S_ADJ2_RD,
    S_ADJ2_WR,
    S_RM_RD,
    S_RM_WR,
    S_REPLY
  } fsm_e;

  typedef struct packed {
    action_e             action;
    logic [NODE_W-1:0]   node_index;
    logic [DEG_W-1:0]    degree;
    logic [DRAW_W-1:0]   draw_first;
    logic [DRAW_W-1:0]   draw_second;
  } rpl_item_t;

  typedef struct packed {
    status_e             status;
    logic [NODE_W-1:0]   node_first;
    logic [NODE_W-1:0]   node_second;
    logic [LINK_W-1:0]   links_placed;
  } rpl_result_t;

  typedef struct packed {
    logic [DEG_W-1:0] target;
    logic [DEG_W-1:0] placed;
  } deg_entry_t;

endpackage

FILE: sv/random_pair_link_placer_top.sv
`timescale 1ns / 1ps
// Top level of the random pair link placer: APB registers, control sequencer
// and the adjacency, degree and open-list memories. Depends on rpl_pkg, rpl_pick.

// After reset the block sweeps its adjacency and placed-degree memories to zero,
// one word a cycle, over max(MAX_NODES*MAX_NODES/64+1, min(MAX_NODES,256))
// addresses (1025 at the default size); busy stays high meanwhile, register
// writes still land. Every accepted transaction gives exactly one result, shown
// for a single cycle on result_o with result_valid_o high, and the receiver
// cannot stall it. A load writes the target degree and, if appended, the list
// entry, then replies. An attempt that finds the graph done or short replies at
// once; any other attempt reads two list entries and the node degrees, then
// swap-removes a full node, stops on a duplicate, or sets the adjacency bit in
// both directions by read-modify-write and swap-removes each node it filled.
// Each step is a dependent access to the single-port memories with a registered read.

module random_pair_link_placer_top import rpl_pkg::*; #(
  parameter int MAX_NODES = 256,
  parameter int DRAW_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  rpl_item_t         item_i,
  output logic              result_valid_o,
  output rpl_result_t       result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int CNT_W      = $clog2(MAX_NODES + 1);
  localparam int LIST_AW    = $clog2(MAX_NODES);
  localparam int NODE_DEPTH = (MAX_NODES < 256) ? MAX_NODES : 256;
  localparam int NODE_AW    = $clog2(NODE_DEPTH);
  localparam int ADJ_WORDS  = MAX_NODES * MAX_NODES / 64 + 1;
  localparam int ADJ_AW     = (ADJ_WORDS > 1) ? $clog2(ADJ_WORDS) : 1;
  localparam int K_W        = ADJ_AW + 6;
  localparam int CLR_LEN    = (ADJ_WORDS > NODE_DEPTH) ? ADJ_WORDS : NODE_DEPTH;
  localparam int CLR_W      = $clog2(CLR_LEN);

  fsm_e state_q, state_d;

  // control state
  logic [LINK_W-1:0]  link_target_q;
  logic [RETRY_W-1:0] retry_limit_q;
  logic [CNT_W-1:0]   open_count_q;
  logic [LINK_W-1:0]  placed_count_q;
  logic [RETRY_W-1:0] dup_run_q;
  logic               stopped_q;
  logic [CLR_W-1:0]   clr_q;
  logic               rm_a_v_q, rm_b_v_q;
  logic [LIST_AW-1:0] rm_a_pos_q, rm_b_pos_q;

  // payload
  rpl_item_t          item_q;
  logic [NODE_W-1:0]  node_i_q, node_j_q;
  deg_entry_t         deg_i_q, deg_j_q;
  rpl_result_t        res_q;

  // memories
  logic [63:0]        adj_mem [ADJ_WORDS];
  logic [63:0]        adj_rd_q, adj_wdata;
  logic [ADJ_AW-1:0]  adj_addr;
  logic               adj_we;

  deg_entry_t         deg_mem [NODE_DEPTH];
  deg_entry_t         deg_rd_q, deg_wdata;
  logic [NODE_AW-1:0] deg_addr;
  logic               deg_we_tgt, deg_we_plc;

  logic [NODE_W-1:0]  list_mem [MAX_NODES];
  logic [NODE_W-1:0]  list_rd_q, list_wdata;
  logic [LIST_AW-1:0] list_addr;
  logic               list_we;

  // helpers
  logic               accept, cfg_wr;
  logic [LIST_AW-1:0] pos_i, pos_j;
  logic               node_in_range, append;
  logic               done_ok, done_short, full_i, full_j;
  logic [K_W-1:0]     k_ij, k_ji;
  logic               dup, give_up, fill_i, fill_j;
  logic [RETRY_W-1:0] dup_next;
  logic [DEG_W-1:0]   plc_i_inc, plc_j_inc;
  logic               nx_a_v, nx_b_v;
  logic [LIST_AW-1:0] nx_a_pos, nx_b_pos;
  logic               clr_last;

  rpl_pick #(
    .MAX_NODES (MAX_NODES),
    .DRAW_BITS (DRAW_BITS)
  ) u_pick (
    .clk_i         (clk_i),
    .load_i        (accept),
    .draw_first_i  (item_i.draw_first),
    .draw_second_i (item_i.draw_second),
    .count_i       (open_count_q),
    .pos_first_o   (pos_i),
    .pos_second_o  (pos_j)
  );

  // ---------------------------------------------------------------- APB
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx_e'(paddr[2]))
      REG_LINK_TARGET: prdata = APB_DW'(link_target_q);
      REG_RETRY_LIMIT: prdata = APB_DW'(retry_limit_q);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- decode
  assign accept        = start && !busy;
  assign node_in_range = 32'(item_q.node_index) < 32'(MAX_NODES);
  assign append        = node_in_range && (item_q.degree != '0)
                         && (open_count_q < CNT_W'(MAX_NODES));
  assign done_ok       = placed_count_q >= link_target_q;
  assign done_short    = stopped_q || (open_count_q < CNT_W'(2));
  assign full_i        = deg_rd_q.placed >= deg_rd_q.target;
  assign full_j        = deg_rd_q.placed >= deg_rd_q.target;

  assign k_ij = K_W'(node_i_q) * K_W'(MAX_NODES) + K_W'(node_j_q);
  assign k_ji = K_W'(node_j_q) * K_W'(MAX_NODES) + K_W'(node_i_q);

  assign dup      = (node_i_q == node_j_q) || adj_rd_q[k_ij[5:0]];
  assign dup_next = (dup_run_q != '1) ? dup_run_q + RETRY_W'(1) : dup_run_q;
  assign give_up  = dup_next >= retry_limit_q;

  assign plc_i_inc = deg_i_q.placed + DEG_W'(1);
  assign plc_j_inc = deg_j_q.placed + DEG_W'(1);
  assign fill_i    = plc_i_inc == deg_i_q.target;
  assign fill_j    = plc_j_inc == deg_j_q.target;

  assign clr_last = clr_q == CLR_W'(CLR_LEN - 1);

  // removal order: higher list position goes first so the lower one stays put
  always_comb begin
    if (pos_i < pos_j) begin
      nx_a_v = fill_j; nx_a_pos = pos_j;
      nx_b_v = fill_i; nx_b_pos = pos_i;
    end else begin
      nx_a_v = fill_i; nx_a_pos = pos_i;
      nx_b_v = fill_j; nx_b_pos = pos_j;
    end
    if (!nx_a_v) begin
      nx_a_v   = nx_b_v;
      nx_a_pos = nx_b_pos;
      nx_b_v   = 1'b0;
    end
  end

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:   if (clr_last) state_d = S_IDLE;
      S_IDLE, S_REPLY: begin
        if (start) state_d = (item_i.action == ACT_LOAD) ? S_LOAD : S_DECIDE;
        else       state_d = S_IDLE;
      end
      S_LOAD:    state_d = S_REPLY;
      S_DECIDE:  state_d = (done_ok || done_short) ? S_REPLY : S_RD_I;
      S_RD_I:    state_d = S_RD_J;
      S_RD_J:    state_d = full_i ? S_RM_RD : S_CHK_J;
      S_CHK_J:   state_d = full_j ? S_RM_RD : S_CHK_A;
      S_CHK_A:   state_d = dup ? S_REPLY : S_ADJ2_RD;
      S_ADJ2_RD: state_d = S_ADJ2_WR;
      S_ADJ2_WR: state_d = rm_a_v_q ? S_RM_RD : S_REPLY;
      S_RM_RD:   state_d = S_RM_WR;
      S_RM_WR:   state_d = rm_b_v_q ? S_RM_RD : S_REPLY;
      default:   state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- outputs
  always_comb begin
    busy           = 1'b1;
    result_valid_o = 1'b0;
    adj_we         = 1'b0;
    adj_addr       = k_ij[K_W-1:6];
    adj_wdata      = adj_rd_q;
    deg_we_tgt     = 1'b0;
    deg_we_plc     = 1'b0;
    deg_addr       = node_i_q[NODE_AW-1:0];
    deg_wdata      = '0;
    list_we        = 1'b0;
    list_addr      = pos_i;
    list_wdata     = list_rd_q;
    case (state_q)
      S_CLEAR: begin
        adj_we     = 32'(clr_q) < 32'(ADJ_WORDS);
        adj_addr   = clr_q[ADJ_AW-1:0];
        adj_wdata  = '0;
        deg_we_plc = 32'(clr_q) < 32'(NODE_DEPTH);
        deg_addr   = clr_q[NODE_AW-1:0];
      end
      S_IDLE: busy = 1'b0;
      S_REPLY: begin
        busy           = 1'b0;
        result_valid_o = 1'b1;
      end
      S_LOAD: begin
        deg_we_tgt       = node_in_range;
        deg_addr         = item_q.node_index[NODE_AW-1:0];
        deg_wdata.target = item_q.degree;
        list_we          = append;
        list_addr        = LIST_AW'(open_count_q);
        list_wdata       = item_q.node_index;
      end
      S_DECIDE: list_addr = pos_i;
      S_RD_I: begin
        deg_addr  = list_rd_q[NODE_AW-1:0];
        list_addr = pos_j;
      end
      S_RD_J:  deg_addr = list_rd_q[NODE_AW-1:0];
      S_CHK_J: adj_addr = k_ij[K_W-1:6];
      S_CHK_A: begin
        adj_we           = !dup;
        adj_addr         = k_ij[K_W-1:6];
        adj_wdata        = adj_rd_q | (64'd1 << k_ij[5:0]);
        deg_we_plc       = !dup;
        deg_addr         = node_i_q[NODE_AW-1:0];
        deg_wdata.placed = plc_i_inc;
      end
      S_ADJ2_RD: begin
        adj_addr         = k_ji[K_W-1:6];
        deg_we_plc       = 1'b1;
        deg_addr         = node_j_q[NODE_AW-1:0];
        deg_wdata.placed = plc_j_inc;
      end
      S_ADJ2_WR: begin
        adj_we    = 1'b1;
        adj_addr  = k_ji[K_W-1:6];
        adj_wdata = adj_rd_q | (64'd1 << k_ji[5:0]);
      end
      S_RM_RD: list_addr = LIST_AW'(open_count_q - CNT_W'(1));
      S_RM_WR: begin
        list_we    = 1'b1;
        list_addr  = rm_a_pos_q;
        list_wdata = list_rd_q;
      end
      default: busy = 1'b1;
    endcase
  end

  assign result_o = res_q;

  // ---------------------------------------------------------------- memories
  always_ff @(posedge clk_i) begin
    if (adj_we) adj_mem[adj_addr] <= adj_wdata;
    adj_rd_q <= adj_mem[adj_addr];
  end

  always_ff @(posedge clk_i) begin
    if (deg_we_tgt) deg_mem[deg_addr].target <= deg_wdata.target;
    if (deg_we_plc) deg_mem[deg_addr].placed <= deg_wdata.placed;
    deg_rd_q <= deg_mem[deg_addr];
  end

  always_ff @(posedge clk_i) begin
    if (list_we) list_mem[list_addr] <= list_wdata;
    list_rd_q <= list_mem[list_addr];
  end

  // ---------------------------------------------------------------- control regs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_CLEAR;
      link_target_q  <= '0;
      retry_limit_q  <= RETRY_RESET;
      open_count_q   <= '0;
      placed_count_q <= '0;
      dup_run_q      <= '0;
      stopped_q      <= 1'b0;
      clr_q          <= '0;
      rm_a_v_q       <= 1'b0;
      rm_b_v_q       <= 1'b0;
      rm_a_pos_q     <= '0;
      rm_b_pos_q     <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        case (reg_idx_e'(paddr[2]))
          REG_LINK_TARGET: link_target_q <= pwdata[LINK_W-1:0];
          REG_RETRY_LIMIT: retry_limit_q <= pwdata[RETRY_W-1:0];
          default: ;
        endcase
      end
      case (state_q)
        S_CLEAR: clr_q <= clr_q + CLR_W'(1);
        S_LOAD:  if (append) open_count_q <= open_count_q + CNT_W'(1);
        S_RD_J: begin
          if (full_i) begin
            rm_a_v_q   <= 1'b1;
            rm_a_pos_q <= pos_i;
            rm_b_v_q   <= 1'b0;
          end
        end
        S_CHK_J: begin
          if (full_j) begin
            rm_a_v_q   <= 1'b1;
            rm_a_pos_q <= pos_j;
            rm_b_v_q   <= 1'b0;
          end
        end
        S_CHK_A: begin
          if (dup) begin
            dup_run_q <= dup_next;
            if (give_up) stopped_q <= 1'b1;
          end else begin
            placed_count_q <= placed_count_q + LINK_W'(1);
            dup_run_q      <= '0;
            rm_a_v_q       <= nx_a_v;
            rm_a_pos_q     <= nx_a_pos;
            rm_b_v_q       <= nx_b_v;
            rm_b_pos_q     <= nx_b_pos;
          end
        end
        S_RM_WR: begin
          open_count_q <= open_count_q - CNT_W'(1);
          rm_a_v_q     <= rm_b_v_q;
          rm_a_pos_q   <= rm_b_pos_q;
          rm_b_v_q     <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- payload regs
  always_ff @(posedge clk_i) begin
    if (accept) item_q <= item_i;
    case (state_q)
      S_LOAD: res_q <= '{STAT_LOADED, item_q.node_index, '0, placed_count_q};
      S_DECIDE: begin
        if (done_ok)         res_q <= '{STAT_DONE_OK, '0, '0, placed_count_q};
        else if (done_short) res_q <= '{STAT_DONE_SHORT, '0, '0, placed_count_q};
      end
      S_RD_I: node_i_q <= list_rd_q;
      S_RD_J: begin
        node_j_q <= list_rd_q;
        deg_i_q  <= deg_rd_q;
        res_q    <= '{STAT_FIRST_FULL, node_i_q, '0, placed_count_q};
      end
      S_CHK_J: begin
        deg_j_q <= deg_rd_q;
        res_q   <= '{STAT_SECOND_FULL, node_i_q, node_j_q, placed_count_q};
      end
      S_CHK_A: begin
        if (!dup)         res_q <= '{STAT_ADDED, node_i_q, node_j_q,
                                     placed_count_q + LINK_W'(1)};
        else if (give_up) res_q <= '{STAT_GAVE_UP, node_i_q, node_j_q, placed_count_q};
        else              res_q <= '{STAT_DUPLICATE, node_i_q, node_j_q, placed_count_q};
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // a load always answers, going from its accept through S_LOAD into S_REPLY
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && item_i.action == ACT_LOAD |-> ##2 result_valid_o)
    else $error("load transaction did not answer on time");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_count_q <= CNT_W'(MAX_NODES))
    else $error("open list count beyond capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> placed_count_q >= $past(placed_count_q))
    else $error("placed link count went down");

  // outside the clearing sweep the adjacency matrix only gains bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adj_we && state_q != S_CLEAR |-> (adj_wdata & adj_rd_q) == adj_rd_q)
    else $error("adjacency write drops an existing link");
`endif

endmodule

FILE: sv/rpl_pick.sv
`timescale 1ns / 1ps
// Maps two random words onto two distinct open-list positions by multiply-high.
// Depends on rpl_pkg.

module rpl_pick import rpl_pkg::*; #(
  parameter int MAX_NODES = 256,
  parameter int DRAW_BITS = 16,
  localparam int CNT_W    = $clog2(MAX_NODES + 1),
  localparam int LIST_AW  = $clog2(MAX_NODES)
) (
  input  logic               clk_i,
  input  logic               load_i,
  input  logic [DRAW_W-1:0]  draw_first_i,
  input  logic [DRAW_W-1:0]  draw_second_i,
  input  logic [CNT_W-1:0]   count_i,
  output logic [LIST_AW-1:0] pos_first_o,
  output logic [LIST_AW-1:0] pos_second_o
);

  localparam int DM_W   = (DRAW_BITS < DRAW_W) ? DRAW_BITS : DRAW_W;
  localparam int PROD_W = DRAW_BITS + CNT_W;

  logic [DM_W-1:0]    dm_first, dm_second;
  logic [CNT_W-1:0]   count_less;
  logic [PROD_W-1:0]  prod_first, prod_second;
  logic [LIST_AW-1:0] pos_first_q, pos_raw_q;

  assign dm_first    = draw_first_i[DM_W-1:0];
  assign dm_second   = draw_second_i[DM_W-1:0];
  assign count_less  = count_i - CNT_W'(1);
  assign prod_first  = PROD_W'(dm_first) * PROD_W'(count_i);
  assign prod_second = PROD_W'(dm_second) * PROD_W'(count_less);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pos_first_q <= LIST_AW'(prod_first[PROD_W-1:DRAW_BITS]);
      pos_raw_q   <= LIST_AW'(prod_second[PROD_W-1:DRAW_BITS]);
    end
  end

  // second position skips over the first so the two never coincide
  assign pos_first_o  = pos_first_q;
  assign pos_second_o = (pos_raw_q >= pos_first_q) ? pos_raw_q + LIST_AW'(1) : pos_raw_q;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for random_pair_link_placer_top: drives load and attempt
// transactions and APB register writes, and predicts every result in a scoreboard.
// Depends on rpl_pkg and the RTL of the block only.

module tb;
  import rpl_pkg::*;

  localparam int NODES          = 256;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int ITEM_GOAL      = 1050;
  localparam int MAX_TARGET     = 32640;

  // Graph builder predictor plus the queue of results it still waits for.
  class link_scoreboard;
    bit            adj [NODES][NODES];
    bit [7:0]      tgt_deg [NODES];
    bit [7:0]      got_deg [NODES];
    bit [7:0]      open_list [NODES];
    int unsigned   open_n;
    int unsigned   peak_open;
    int unsigned   links;
    int unsigned   dup_run;
    bit            halted;
    bit [14:0]     link_target;
    bit [15:0]     retry_limit;
    rpl_result_t   expected_results [$];
    int unsigned   mismatches;
    int unsigned   checked;
    int unsigned   seen [8];

    function new();
      retry_limit = RETRY_RESET;
    endfunction

    function void set_reg(reg_idx_e idx, logic [31:0] v);
      case (idx)
        REG_LINK_TARGET: link_target = v[14:0];
        REG_RETRY_LIMIT: retry_limit = v[15:0];
        default: ;
      endcase
    endfunction

    function bit is_full(bit [7:0] node);
      return got_deg[node] >= tgt_deg[node];
    endfunction

    function int unsigned pick(bit [15:0] d, int unsigned n);
      return (32'(d) * n) >> DRAW_W;
    endfunction

    // swap-remove: last entry moves into the freed slot
    function void remove_at(int unsigned pos);
      if (pos < open_n && open_n > 0) begin
        open_list[pos] = open_list[open_n - 1];
        open_n--;
      end
    endfunction

    function status_e note_item(rpl_item_t it);
      rpl_result_t r;
      int unsigned ik, jk;
      bit [7:0]    a, b;
      r = '0;
      if (it.action == ACT_LOAD) begin
        r.status = STAT_LOADED;
        r.node_first = it.node_index;
        tgt_deg[it.node_index] = it.degree;
        if (it.degree != 0 && open_n < NODES) begin
          open_list[open_n] = it.node_index;
          open_n++;
        end
        if (open_n > peak_open) peak_open = open_n;
      end else if (links >= link_target) begin
        r.status = STAT_DONE_OK;
      end else if (halted || open_n < 2) begin
        r.status = STAT_DONE_SHORT;
      end else begin
        ik = pick(it.draw_first, open_n);
        a = open_list[ik];
        r.node_first = a;
        if (is_full(a)) begin
          remove_at(ik);
          r.status = STAT_FIRST_FULL;
        end else begin
          jk = pick(it.draw_second, open_n - 1);
          if (jk >= ik) jk++;
          b = open_list[jk];
          r.node_second = b;
          if (is_full(b)) begin
            remove_at(jk);
            r.status = STAT_SECOND_FULL;
          end else if (b == a || adj[a][b]) begin
            if (dup_run < 32'hFFFF) dup_run++;
            if (dup_run >= retry_limit) begin
              halted = 1'b1;
              r.status = STAT_GAVE_UP;
            end else begin
              r.status = STAT_DUPLICATE;
            end
          end else begin
            adj[a][b] = 1'b1;
            adj[b][a] = 1'b1;
            got_deg[a]++;
            got_deg[b]++;
            links++;
            dup_run = 0;
            // remove the higher slot first so the lower index stays valid
            if (ik < jk) begin
              if (got_deg[b] == tgt_deg[b]) remove_at(jk);
              if (got_deg[a] == tgt_deg[a]) remove_at(ik);
            end else begin
              if (got_deg[a] == tgt_deg[a]) remove_at(ik);
              if (got_deg[b] == tgt_deg[b]) remove_at(jk);
            end
            r.status = STAT_ADDED;
          end
        end
      end
      r.links_placed = links[14:0];
      expected_results = {expected_results, r};
      return r.status;
    endfunction

    function void check_result(rpl_result_t got);
      rpl_result_t exp;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d first %0d second %0d links %0d",
                   got.status, got.node_first, got.node_second, got.links_placed);
        return;
      end
      exp = expected_results.pop_front();
      checked++;
      seen[exp.status]++;
      if (got.status !== exp.status || got.node_first !== exp.node_first ||
          got.node_second !== exp.node_second || got.links_placed !== exp.links_placed) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch on result %0d: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                   checked, exp.status, exp.node_first, exp.node_second, exp.links_placed,
                   got.status, got.node_first, got.node_second, got.links_placed);
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  rpl_item_t         item_i;
  logic              result_valid_o;
  rpl_result_t       result_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  link_scoreboard sb;
  int unsigned    items_sent;
  int unsigned    idle_pct;
  status_e        last_status;

  random_pair_link_placer_top u_dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .item_i,
    .result_valid_o,
    .result_o,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o === 1'b1) sb.check_result(result_o);
  end

  initial begin
    int unsigned quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (start && !busy) || result_valid_o) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("simulation failed");
    $finish;
  end

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(int'(idx) * 4);
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic send_item(input rpl_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    last_status = sb.note_item(it);
    items_sent++;
    idle_pct = (items_sent < 350) ? 24 : (items_sent < 700) ? 66 : 0;
  endtask

  // stop issuing and wait until the block has answered everything and gone idle
  task automatic drain();
    start <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic load_node(input int unsigned node, input int unsigned deg);
    rpl_item_t it;
    it.action      = ACT_LOAD;
    it.node_index  = node[7:0];
    it.degree      = deg[7:0];
    it.draw_first  = 16'($urandom);
    it.draw_second = 16'($urandom);
    send_item(it);
  endtask

  task automatic try_pair(input bit [15:0] d1, input bit [15:0] d2);
    rpl_item_t it;
    it.action      = ACT_ATTEMPT;
    it.node_index  = 8'($urandom);
    it.degree      = 8'($urandom);
    it.draw_first  = d1;
    it.draw_second = d2;
    send_item(it);
  endtask

  // smallest draw that lands on list position p out of n
  function automatic bit [15:0] draw_for(int unsigned p, int unsigned n);
    return 16'((p * 65536 + n - 1) / n);
  endfunction

  task automatic try_at(input int unsigned p, input int unsigned q);
    int unsigned n, qq;
    n = sb.open_n;
    if (n < 2) begin
      try_pair(16'($urandom), 16'($urandom));
    end else begin
      p = p % n;
      q = q % n;
      if (q == p) q = (p + 1) % n;
      qq = (q > p) ? q - 1 : q;
      try_pair(draw_for(p, n), draw_for(qq, n - 1));
    end
  endtask

  // two open slots holding non-full nodes that are already linked or identical
  function automatic bit find_dup_pair(output int unsigned p, output int unsigned q);
    bit [7:0] a, b;
    p = 0;
    q = 0;
    for (int unsigned i = 0; i < sb.open_n; i++) begin
      for (int unsigned j = 0; j < sb.open_n; j++) begin
        a = sb.open_list[i];
        b = sb.open_list[j];
        if (i != j && !sb.is_full(a) && !sb.is_full(b) && (a == b || sb.adj[a][b])) begin
          p = i;
          q = j;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  initial begin
    int unsigned fresh [$];
    int unsigned rnodes [$];
    int unsigned rdegs [$];
    int unsigned k, sum, lt, deg, p, q, extra;

    sb          = new();
    items_sent  = 0;
    idle_pct    = 24;
    last_status = STAT_LOADED;
    rst_ni  <= 1'b0;
    start   <= 1'b0;
    item_i  <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: done checks, reload, full nodes, same node twice, linked pair
    write_reg(REG_LINK_TARGET, 0);
    try_pair(16'h0000, 16'h0000);
    drain();
    write_reg(REG_LINK_TARGET, MAX_TARGET);
    write_reg(REG_RETRY_LIMIT, 32'hFFFF);
    try_pair(16'hFFFF, 16'hFFFF);
    load_node(255, 0);
    load_node(0, 255);
    load_node(254, 1);
    load_node(1, 3);
    try_at(0, 1);
    try_pair(16'h0000, 16'hFFFF);
    load_node(254, 1);
    try_at(2, 0);
    load_node(254, 1);
    try_at(0, 2);
    load_node(0, 255);
    try_at(0, 2);
    try_at(0, 1);
    try_at(1, 0);
    try_pair(16'hFFFF, 16'h0000);
    try_pair(16'hFFFF, 16'hFFFF);

    // random graph rounds on fresh nodes
    for (int unsigned i = 2; i < 254; i++) fresh = {fresh, i};
    while (items_sent < 600 && fresh.size() >= 24) begin
      drain();
      rnodes.delete();
      rdegs.delete();
      sum = 0;
      k = $urandom_range(8, 24);
      repeat (k) begin
        p = $urandom_range(0, fresh.size() - 1);
        rnodes = {rnodes, fresh[p]};
        fresh.delete(p);
        if ($urandom_range(9) == 0) deg = 0;
        else if ($urandom_range(24) == 0) deg = $urandom_range(100, 255);
        else deg = $urandom_range(1, 5);
        rdegs = {rdegs, deg};
        sum += deg;
      end
      lt = sb.links + sum / 2;
      if (lt > MAX_TARGET) lt = MAX_TARGET;
      write_reg(REG_LINK_TARGET, lt);
      write_reg(REG_RETRY_LIMIT,
                $urandom_range(1) ? 32'hFFFF : $urandom_range(2000, 65534));
      foreach (rnodes[i]) load_node(rnodes[i], rdegs[i]);
      for (int a = 0; a < 120; a++) begin
        try_pair(16'($urandom), 16'($urandom));
        if (last_status == STAT_DONE_OK || last_status == STAT_DONE_SHORT) break;
      end
    end

    // reload at random until the open list overflows, then work on the crowded list
    drain();
    write_reg(REG_LINK_TARGET, MAX_TARGET);
    write_reg(REG_RETRY_LIMIT, 32'hFFFF);
    extra = 0;
    while (extra < 3) begin
      if (sb.open_n == NODES) extra++;
      deg = (sb.open_n == NODES || $urandom_range(9) != 0) ? $urandom_range(1, 255) : 0;
      load_node($urandom_range(0, 255), deg);
    end
    while (items_sent < ITEM_GOAL - 20) try_pair(16'($urandom), 16'($urandom));

    // zero retry limit: the first duplicate stops the block for good
    drain();
    write_reg(REG_RETRY_LIMIT, 0);
    for (int a = 0; a < 60 && last_status != STAT_GAVE_UP; a++) begin
      if (find_dup_pair(p, q)) try_at(p, q);
      else try_pair(16'($urandom), 16'($urandom));
    end
    try_pair(16'hFFFF, 16'h0000);
    load_node($urandom_range(0, 255), $urandom_range(1, 255));
    try_pair(16'($urandom), 16'($urandom));

    drain();
    repeat (16) @(posedge clk_i);

    if (sb.expected_results.size() != 0)
      $display("%0d expected results never arrived", sb.expected_results.size());
    $display("%0d transactions checked: %0d loads, %0d links added, %0d full-node skips,",
             sb.checked, sb.seen[STAT_LOADED], sb.seen[STAT_ADDED],
             sb.seen[STAT_FIRST_FULL] + sb.seen[STAT_SECOND_FULL]);
    $display("%0d duplicates, %0d give-ups, %0d done ok, %0d done short; open list peak %0d",
             sb.seen[STAT_DUPLICATE], sb.seen[STAT_GAVE_UP], sb.seen[STAT_DONE_OK],
             sb.seen[STAT_DONE_SHORT], sb.peak_open);
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
